// ----- hdl/csc_pkg.sv -----
// shared constants, command codes and controller/datapath interface types
package csc_pkg;

  // store geometry
  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 64;

  // port field widths
  localparam int CMD_W   = 2;
  localparam int KEY_W   = 64;
  localparam int SIZE_W  = 64;
  localparam int ENTRY_W = 7;

  // derived widths
  localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam slot_t LAST_SLOT = SLOT_W'(CAPACITY - 1);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic decide;
    logic sweep;
  } dp_ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_req;
    logic slot_free;
  } dp_status_t;

endpackage

// ----- hdl/csc_datapath.sv -----
// slot store, key match, clock hand, size memory and result registers
module csc_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  csc_pkg::dp_ctrl_t            ctrl,
  output csc_pkg::dp_status_t          status,
  input  logic [csc_pkg::CMD_W-1:0]    in_cmd,
  input  logic [csc_pkg::KEY_W-1:0]    in_key,
  input  logic [csc_pkg::SIZE_W-1:0]   in_new_size,
  output logic                         out_hit,
  output logic [csc_pkg::SIZE_W-1:0]   out_stored_size,
  output logic [csc_pkg::ENTRY_W-1:0]  out_entry_count
);
  import csc_pkg::*;

  // latched beat
  logic [CMD_W-1:0]    cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [SIZE_W-1:0]   size_r;

  // slot state
  logic [KEY_BITS-1:0] keys_r [CAPACITY];
  logic [SIZE_W-1:0]   size_mem [CAPACITY];
  logic [SIZE_W-1:0]   rd_data_r;
  logic [CAPACITY-1:0] valid_r;
  logic [CAPACITY-1:0] visited_r;
  logic [CAPACITY-1:0] match_r;
  logic [CAPACITY-1:0] match_nxt;
  slot_t               hand_r;
  slot_t               hand_inc;
  count_t              count_r;

  // result registers
  logic                res_hit_r;
  logic                res_sel_r;

  // match decode
  logic                found;
  slot_t               idx;
  logic                mem_we;
  slot_t               mem_waddr;

  // keys are unique among valid slots, so an or-reduction encodes the match
  function automatic slot_t encode(input logic [CAPACITY-1:0] m);
    slot_t r;
    r = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (m[i]) r = r | SLOT_W'(i);
    end
    return r;
  endfunction

  // parallel compare of the incoming key against every valid slot
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match_nxt[i] = valid_r[i] && (keys_r[i] == in_key[KEY_BITS-1:0]);
    end
  end

  assign found    = |match_r;
  assign idx      = encode(match_r);
  assign hand_inc = (hand_r == LAST_SLOT) ? '0 : hand_r + 1'b1;

  // status back to the controller
  assign status.sweep_req = !found && (cmd_r == CMD_INSERT);
  assign status.slot_free = !visited_r[hand_r];

  // capture beat and match vector on accept
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cmd_r   <= in_cmd;
      key_r   <= in_key[KEY_BITS-1:0];
      size_r  <= in_new_size;
      match_r <= match_nxt;
    end
  end

  // key install at the hand
  always_ff @(posedge clk) begin
    if (ctrl.sweep && status.slot_free) begin
      keys_r[hand_r] <= key_r;
    end
  end

  // size memory write port: update on insert hit, install on sweep end
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hand_r;
    if (ctrl.decide && found && (cmd_r == CMD_INSERT)) begin
      mem_we    = 1'b1;
      mem_waddr = idx;
    end else if (ctrl.sweep && status.slot_free) begin
      mem_we    = 1'b1;
    end
  end

  // size memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[mem_waddr] <= size_r;
    end
    if (ctrl.decide) begin
      rd_data_r <= size_mem[idx];
    end
  end

  // marks, hand, count and result flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      visited_r <= '0;
      hand_r    <= '0;
      count_r   <= '0;
      res_hit_r <= 1'b0;
      res_sel_r <= 1'b0;
    end else begin
      if (ctrl.decide) begin
        res_hit_r <= found && (cmd_r inside {CMD_LOOKUP, CMD_INSERT, CMD_REMOVE});
        res_sel_r <= found && (cmd_r == CMD_LOOKUP);
        if (found) begin
          case (cmd_r)
            CMD_LOOKUP: begin
              visited_r[idx] <= 1'b1;
            end
            CMD_REMOVE: begin
              valid_r[idx]   <= 1'b0;
              visited_r[idx] <= 1'b0;
              if (count_r != '0) count_r <= count_r - 1'b1;
            end
            default: ;
          endcase
        end
      end
      if (ctrl.sweep) begin
        if (visited_r[hand_r]) begin
          // second chance: clear the mark and move on
          visited_r[hand_r] <= 1'b0;
        end else begin
          // victim slot: take it over
          valid_r[hand_r] <= 1'b1;
          if (!valid_r[hand_r]) count_r <= count_r + 1'b1;
        end
        hand_r <= hand_inc;
      end
    end
  end

  // result ports
  assign out_hit         = res_hit_r;
  assign out_stored_size = res_sel_r ? rd_data_r : '0;
  assign out_entry_count = ENTRY_W'(count_r);

`ifndef SYNTHESIS
  a_match_unique: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.decide |-> $onehot0(match_r))
    else $error("more than one slot matches the key");

  a_count_tracks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == COUNT_W'($countones(valid_r)))
    else $error("entry count disagrees with valid marks");

  a_hand_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.sweep |=> hand_r != $past(hand_r))
    else $error("clock hand did not advance on a sweep step");
`endif

endmodule

// ----- hdl/csc_ctrl.sv -----
// command sequencer: accept, decide, sweep and result strobe
module csc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_valid,
  output csc_pkg::dp_ctrl_t    ctrl,
  input  csc_pkg::dp_status_t  status
);
  import csc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_SWEEP
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  // datapath commands
  assign ctrl.load   = (state_r == S_IDLE) && start;
  assign ctrl.decide = (state_r == S_DECIDE);
  assign ctrl.sweep  = (state_r == S_SWEEP);
  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;

  // state and result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (status.sweep_req) begin
            state_r <= S_SWEEP;
          end else begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_SWEEP: begin
          if (status.slot_free) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_strobe_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe outside idle");

  a_decide_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DECIDE |-> $past(state_r) == S_IDLE && $past(start))
    else $error("decide entered without an accepted beat");

  a_load_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |=> state_r == S_DECIDE)
    else $error("accepted beat did not move to decide");
`endif

endmodule

// ----- hdl/clock_replacement_size_cache.sv -----
// top level: clock replacement cache of object sizes keyed by a fixed-width key
//
//   channel  handshake         ports
//   input    start & !busy     in_cmd, in_key, in_new_size
//   result   out_valid strobe  out_hit, out_stored_size, out_entry_count
//
// lookup, remove, insert of a present key and unused commands pass from accept
// through decide and back to idle; the result strobe is registered and comes in
// the cycle after the decide cycle
// insert of an absent key adds a sweep in which the clock hand clears visited
// marks one slot per cycle until an unmarked slot takes the key
// synchronous active-low reset clears marks, hand and count; keys and sizes
// are not cleared
// the result strobe lasts one cycle and cannot be held off
module clock_replacement_size_cache (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [csc_pkg::CMD_W-1:0]    in_cmd,
  input  logic [csc_pkg::KEY_W-1:0]    in_key,
  input  logic [csc_pkg::SIZE_W-1:0]   in_new_size,
  output logic                         out_valid,
  output logic                         out_hit,
  output logic [csc_pkg::SIZE_W-1:0]   out_stored_size,
  output logic [csc_pkg::ENTRY_W-1:0]  out_entry_count
);
  import csc_pkg::*;

  dp_ctrl_t   ctrl;
  dp_status_t status;

  // sequencer
  csc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .ctrl      (ctrl),
    .status    (status)
  );

  // store and result datapath
  csc_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .status          (status),
    .in_cmd          (in_cmd),
    .in_key          (in_key),
    .in_new_size     (in_new_size),
    .out_hit         (out_hit),
    .out_stored_size (out_stored_size),
    .out_entry_count (out_entry_count)
  );

endmodule
